// ----- hdl/clt_pkg.sv -----
// Package for the CPU load block: sizes, constants and the queued item type.
// No dependencies; every other file but clt_ram imports it.
package clt_pkg;

  localparam int MAX_CPUS       = 64;
  localparam int STATES_PER_CPU = 5;
  localparam int TICK_W         = 32;
  localparam int SUM_W          = 13;
  localparam int IDX_W          = 3;
  localparam int POS_W          = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int ROW_W          = TICK_W * STATES_PER_CPU;
  localparam int QUOT_W         = 7;
  localparam int PROD_W         = TICK_W + QUOT_W;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [IDX_W-1:0]  IDLE_IDX_RESET = 3'd4;
  localparam logic [IDX_W-1:0]  IDLE_IDX_MAX   = 3'd4;
  localparam logic [QUOT_W-1:0] PERCENT        = 7'd100;
  localparam logic [SUM_W-1:0]  SUM_MAX        = 13'd8191;

  localparam logic [0:0] REG_IDLE_IDX = 1'b0;

  typedef struct packed {
    logic [STATES_PER_CPU-1:0][TICK_W-1:0] ticks;
    logic                                  last;
  } clt_item_t;

endpackage

// ----- hdl/clt_ifs.sv -----
// Stream interfaces of the CPU load block: tick counter beats in, load beats out.
// Depends on clt_pkg.
interface clt_in_if import clt_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] ticks_0;
  logic [TICK_W-1:0] ticks_1;
  logic [TICK_W-1:0] ticks_2;
  logic [TICK_W-1:0] ticks_3;
  logic [TICK_W-1:0] ticks_4;
  logic              last_cpu;

  modport source (output valid, ticks_0, ticks_1, ticks_2, ticks_3, ticks_4, last_cpu,
                  input ready);
  modport sink   (input valid, ticks_0, ticks_1, ticks_2, ticks_3, ticks_4, last_cpu,
                  output ready);
endinterface

interface clt_out_if import clt_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] load_sum;

  modport source (output valid, load_sum, input ready);
  modport sink   (input valid, load_sum, output ready);
endinterface

// ----- hdl/clt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/clt_front.sv -----
// Front end: accepts tick counter beats into a short queue for the back end.
// Depends on clt_pkg and clt_in_if.
module clt_front import clt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  clt_in_if.sink    in_i,
  output logic      head_valid_o,
  output clt_item_t head_o,
  input  logic      pop_i
);

  clt_item_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               push, pop;
  clt_item_t          item;

  assign item.ticks = {in_i.ticks_4, in_i.ticks_3, in_i.ticks_2, in_i.ticks_1, in_i.ticks_0};
  assign item.last  = in_i.last_cpu;

  assign in_i.ready   = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hdl/clt_back.sv -----
// Back end: per-CPU deltas against stored counters, bit-serial busy percentage,
// load accumulation and the output register. Depends on clt_pkg, clt_ram, clt_out_if.
module clt_back import clt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  clt_item_t        head_i,
  output logic             pop_o,
  input  logic [IDX_W-1:0] idle_idx_i,
  clt_out_if.source        out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SUM, S_CHECK, S_DIV, S_ACC
  } state_e;

  state_e                                state_q;
  logic [STATES_PER_CPU-1:0][TICK_W-1:0] cur_q, delta_q;
  logic                                  last_q;
  logic [POS_W-1:0]                      pos_q;
  logic [MAX_CPUS-1:0]                   row_valid_q;
  logic [TICK_W-1:0]                     total_q;
  logic [PROD_W-1:0]                     prod_q, rem_q, div_q;
  logic [QUOT_W-1:0]                     quot_q;
  logic [2:0]                            step_q;
  logic                                  add_q;
  logic [SUM_W-1:0]                      acc_q, out_sum_q;
  logic                                  out_valid_q;

  logic [ROW_W-1:0]  rdata;
  logic [IDX_W-1:0]  idx;
  logic [TICK_W-1:0] total_d;
  logic [PROD_W-1:0] prod_d, total_x128;
  logic [QUOT_W-1:0] term;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_sat;
  logic              ram_we, out_free, done;
  logic [TICK_W-1:0] prev [STATES_PER_CPU];

  assign pop_o  = (state_q == S_IDLE) && head_valid_i;
  assign ram_we = (state_q == S_READ);

  clt_ram #(.WIDTH(ROW_W), .DEPTH(MAX_CPUS), .AW(POS_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (cur_q),
    .re_i    (pop_o),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int s = 0; s < STATES_PER_CPU; s++) begin
      prev[s] = row_valid_q[pos_q] ? rdata[s*TICK_W +: TICK_W] : '0;
    end
  end

  assign idx        = (idle_idx_i > IDLE_IDX_MAX) ? IDLE_IDX_MAX : idle_idx_i;
  assign total_d    = ((delta_q[0] + delta_q[1]) + (delta_q[2] + delta_q[3])) + delta_q[4];
  assign prod_d     = PROD_W'(delta_q[idx]) * PROD_W'(PERCENT);
  assign total_x128 = {total_q, {QUOT_W{1'b0}}};
  assign term       = (quot_q >= PERCENT) ? '0 : PERCENT - quot_q;
  assign sum_wide   = {1'b0, acc_q} + (SUM_W + 1)'(term);
  assign sum_sat    = (sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign out_free   = !out_valid_q || out_o.ready;
  assign done       = (state_q == S_ACC) && (!last_q || out_free);

  assign out_o.valid    = out_valid_q;
  assign out_o.load_sum = out_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      row_valid_q <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !(done && last_q)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            cur_q   <= head_i.ticks;
            last_q  <= head_i.last;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          for (int s = 0; s < STATES_PER_CPU; s++) begin
            delta_q[s] <= cur_q[s] - prev[s];
          end
          row_valid_q[pos_q] <= 1'b1;
          state_q            <= S_SUM;
        end
        S_SUM: begin
          total_q <= total_d;
          prod_q  <= prod_d;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          add_q  <= (total_q != '0);
          quot_q <= '1;
          if (total_q == '0 || prod_q >= total_x128) begin
            state_q <= S_ACC;
          end else begin
            rem_q   <= prod_q;
            div_q   <= {1'b0, total_q, {(QUOT_W - 1){1'b0}}};
            quot_q  <= '0;
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_q >= div_q) begin
            rem_q  <= rem_q - div_q;
            quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
          end else begin
            quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
          end
          div_q  <= div_q >> 1;
          step_q <= step_q + 1'b1;
          if (step_q == 3'(QUOT_W - 1)) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (!last_q) begin
            if (add_q) begin
              acc_q <= sum_sat;
            end
            pos_q   <= (pos_q == POS_W'(MAX_CPUS - 1)) ? '0 : pos_q + 1'b1;
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_sum_q   <= add_q ? sum_sat : acc_q;
            out_valid_q <= 1'b1;
            acc_q       <= '0;
            pos_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(last_q) && $past(state_q == S_ACC))
    else $error("result raised without a last CPU");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < total_x128))
    else $error("division remainder out of range");

  a_snapshot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && last_q) |=> (pos_q == '0) && (acc_q == '0))
    else $error("snapshot end did not clear position and sum");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_CPUS - 1))
    else $error("CPU position beyond table");

endmodule

// ----- hdl/cpu_load_from_tick_counters_core.sv -----
// Top level of the CPU load block: APB register, front queue and back end.
// Depends on clt_pkg, clt_ifs, clt_front, clt_back.
//
//   port     dir  beat payload
//   in_i     in   ticks_0..ticks_4 (32 b each), last_cpu (1 b)
//   out_o    out  load_sum (13 b), one beat per snapshot, on the last CPU
//   apb      in   idle_state_index at byte address 0
//
// Each CPU beat holds the back end through read, sum, check, the seven-step quotient loop
// and accumulate; the loop is skipped when its total is zero or its idle share reaches 128 percent.
// The queue takes two further beats while the back end works.
// Reset clears the per-CPU valid flags at once, so no clearing sweep is needed.
// A last-CPU beat waits in the back end while the previous load beat is not taken.
module cpu_load_from_tick_counters_core import clt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  clt_in_if.sink            in_i,
  clt_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [IDX_W-1:0] idle_idx_q;
  logic             head_valid, pop;
  clt_item_t        head;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_IDLE_IDX);
  assign prdata  = reg_hit ? DATA_W'(idle_idx_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_idx_q <= IDLE_IDX_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      idle_idx_q <= pwdata[IDX_W-1:0];
    end
  end

  clt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  clt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .idle_idx_i   (idle_idx_q),
    .out_o        (out_o)
  );

endmodule
